// ===== hdl/itoa_pkg.sv =====
// Shared constants, mode codes and the digit-to-character map for the integer-to-ASCII converter.
package itoa_pkg;

  // Fixed payload widths of the channels
  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CHAR_W     = 8;

  // Mode codes; bit 1 of the mode selects hexadecimal
  localparam logic [MODE_W-1:0] MODE_UNSIGNED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SIGNED   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX      = 2'd2;
  localparam int unsigned       MODE_HEX_BIT  = 1;

  // Characters
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0]        DEC_BASE    = 4'd10;

  // One digit (0..15) to its ASCII character, uppercase hex letters
  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] digit);
    logic [CHAR_W-1:0] ext;
    ext = {4'b0000, digit};
    if (digit < DEC_BASE) begin
      return ASCII_ZERO + ext;
    end else begin
      return ASCII_UPPER + ext - {4'b0000, DEC_BASE};
    end
  endfunction

endpackage

// ===== hdl/itoa_if.sv =====
// Valid/ready channel interfaces for the number input and the character output.
interface itoa_in_if import itoa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [IN_VALUE_W-1:0] value;
  logic [MODE_W-1:0]     mode;

  modport source (output valid, output value, output mode, input ready);
  modport sink   (input valid, input value, input mode, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink   (input valid, input ascii_char, input last, output ready);
endinterface

// ===== hdl/itoa_bcd_step.sv =====
// One shift-add-3 step of the binary to BCD conversion over all digits.
module itoa_bcd_step #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic [4*NUM_DIGITS-1:0] digits_i,
  input  logic                    bit_i,
  output logic [4*NUM_DIGITS-1:0] digits_o
);

  localparam int unsigned DW = 4 * NUM_DIGITS;

  logic [DW-1:0] adj;

  // Add 3 to every digit of 5 or more, then shift the next binary bit in
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits_i[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = digits_i[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = digits_i[4*i +: 4];
      end
    end
  end

  assign digits_o = {adj[DW-2:0], bit_i};

endmodule

// ===== hdl/integer_to_ascii_digits_top.sv =====
// Top level: converts one number to a burst of ASCII characters, most significant first.
//
//  channel | dir | transfer when  | payload
//  --------+-----+----------------+---------------------------------------
//  in_i    | in  | valid & ready  | value[31:0], mode[1:0] (0 udec, 1 sdec, 2/3 hex)
//  out_o   | out | valid & ready  | ascii_char[7:0], last (final char of number)
//
// Decimal: accept the number, run VALUE_WIDTH shift-add-3 steps, drop the leading
// zeros of the result, then emit a '-' when negative, followed by the characters.
// Hex skips the BCD loop and goes from accept straight to dropping leading zeros.
// A stalled output holds the sequencer; the next number is taken while the last
// character still waits.
// Reset clears the sequencer and the output valid; no clearing pass.
module integer_to_ascii_digits_top import itoa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  itoa_in_if.sink           in_i,
  itoa_out_if.source        out_o
);

  // Decimal digits of 2^VALUE_WIDTH-1; always at least the hex digit count
  localparam int unsigned NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned DW         = 4 * NUM_DIGITS;
  localparam int unsigned BW         = $clog2(VALUE_WIDTH);
  localparam int unsigned CW         = $clog2(NUM_DIGITS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [VALUE_WIDTH-1:0] bin_q, bin_d;
  logic [DW-1:0]          digits_q, digits_d;
  logic [BW-1:0]          bits_q, bits_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic                   out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]      out_char_q, out_char_d;
  logic                   out_last_q, out_last_d;

  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_neg;
  logic                   in_hex;
  logic [DW-1:0]          step_digits;
  logic [3:0]             top_digit;
  logic                   out_free;

  // Input decode
  assign in_val = VALUE_WIDTH'(in_i.value);
  assign in_hex = in_i.mode[MODE_HEX_BIT];
  assign in_neg = (in_i.mode == MODE_SIGNED) && in_val[VALUE_WIDTH-1];

  assign top_digit = digits_q[DW-1 -: 4];
  assign out_free  = !out_valid_q || out_o.ready;

  // Shared BCD step
  itoa_bcd_step #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_bcd_step (
    .digits_i(digits_q),
    .bit_i   (bin_q[VALUE_WIDTH-1]),
    .digits_o(step_digits)
  );

  // Sequencer
  always_comb begin
    state_d     = state_q;
    bin_d       = bin_q;
    digits_d    = digits_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          neg_d = in_neg && !in_hex;
          cnt_d = CW'(NUM_DIGITS);
          if (in_hex) begin
            digits_d = DW'(in_val);
            state_d  = ST_SKIP;
          end else begin
            bin_d    = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;
            digits_d = '0;
            bits_d   = BW'(VALUE_WIDTH - 1);
            state_d  = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        digits_d = step_digits;
        bin_d    = bin_q << 1;
        bits_d   = bits_q - BW'(1);
        if (bits_q == '0) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keep at least one digit
        if (top_digit == 4'd0 && cnt_q > CW'(1)) begin
          digits_d = digits_q << 4;
          cnt_d    = cnt_q - CW'(1);
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = ASCII_MINUS;
          out_last_d  = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_char_d  = digit_char(top_digit);
          out_last_d  = (cnt_q == CW'(1));
          digits_d    = digits_q << 4;
          cnt_d       = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    digits_q   <= digits_d;
    bits_q     <= bits_d;
    cnt_q      <= cnt_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = out_char_q;
  assign out_o.last       = out_last_q;

endmodule
